[sv/three_channel_rms_meter_macros.svh]
// Assertion macros for the three-channel RMS meter.
// Used by the controller and datapath modules; needs no other file.
`ifndef THREE_CHANNEL_RMS_METER_MACROS_SVH
`define THREE_CHANNEL_RMS_METER_MACROS_SVH
`ifndef SYNTHESIS
`define TCRMS_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tcrms check failed");
`define TCRMS_ASSERT_RESET(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("tcrms reset check failed");
`else
`define TCRMS_ASSERT(name, clk, rst, prop)
`define TCRMS_ASSERT_RESET(name, clk, prop)
`endif
`endif

[sv/tcrms_pkg.sv]
// Package for the three-channel RMS meter: widths, constants and transfer types.
// No dependencies; used by every module of the block.
package tcrms_pkg;

   // Window length is 2^SAMPLE_SHIFT ticks.
   localparam int SAMPLE_SHIFT = 6;
   localparam int WINDOW_LEN   = 1 << SAMPLE_SHIFT;
   localparam int SAMPLE_W     = 16;
   localparam int SQUARE_W     = 2 * SAMPLE_W;
   localparam int SUM_W        = SQUARE_W + SAMPLE_SHIFT;
   localparam int CNT_W        = SAMPLE_SHIFT + 1;
   localparam int ROOT_W       = SAMPLE_W;
   localparam int RMS_W        = 26;
   localparam int ITER_W       = 5;
   localparam int SQRT_STEPS   = ROOT_W;
   localparam int DIV_STEPS    = RMS_W;
   localparam int SREM_W       = ROOT_W + 2;

   localparam logic [SAMPLE_W-1:0] MILLI = 16'd1000;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_SCALE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_OFFSET  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_SCALE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_OFFSET = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLT_SCALE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_VOLT_OFFSET = 3'd5;

   // Register values after reset.
   localparam logic [SAMPLE_W-1:0] LOW_SCALE_RST   = 16'd874;
   localparam logic [SAMPLE_W-1:0] HIGH_SCALE_RST  = 16'd8738;
   localparam logic [SAMPLE_W-1:0] VOLT_SCALE_RST  = 16'd79;
   localparam logic [SAMPLE_W-1:0] OFFSET_RST      = 16'd32768;

   // Channel codes.
   localparam logic [1:0] CH_LOW  = 2'd0;
   localparam logic [1:0] CH_HIGH = 2'd1;
   localparam logic [1:0] CH_VOLT = 2'd2;

   // Datapath operations issued by the controller.
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
   localparam logic [OP_W-1:0] OP_LOAD      = 4'd1;
   localparam logic [OP_W-1:0] OP_CLEAR_ALL = 4'd2;
   localparam logic [OP_W-1:0] OP_SQUARE    = 4'd3;
   localparam logic [OP_W-1:0] OP_ACCUM     = 4'd4;
   localparam logic [OP_W-1:0] OP_TICK      = 4'd5;
   localparam logic [OP_W-1:0] OP_ROOT_INIT = 4'd6;
   localparam logic [OP_W-1:0] OP_ROOT_STEP = 4'd7;
   localparam logic [OP_W-1:0] OP_SCALE     = 4'd8;
   localparam logic [OP_W-1:0] OP_DIV_INIT  = 4'd9;
   localparam logic [OP_W-1:0] OP_DIV_STEP  = 4'd10;
   localparam logic [OP_W-1:0] OP_STORE     = 4'd11;
   localparam logic [OP_W-1:0] OP_PUBLISH   = 4'd12;

   typedef struct packed {
      logic                restart;
      logic [SAMPLE_W-1:0] low_gain_sample;
      logic [SAMPLE_W-1:0] high_gain_sample;
      logic [SAMPLE_W-1:0] voltage_sample;
   } req_type;

   typedef struct packed {
      logic [RMS_W-1:0] low_gain_rms;
      logic [RMS_W-1:0] high_gain_rms;
      logic [RMS_W-1:0] voltage_rms;
      logic             window_done;
   } rsp_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] low_gain_scale;
      logic [SAMPLE_W-1:0] low_gain_offset;
      logic [SAMPLE_W-1:0] high_gain_scale;
      logic [SAMPLE_W-1:0] high_gain_offset;
      logic [SAMPLE_W-1:0] voltage_scale;
      logic [SAMPLE_W-1:0] voltage_offset;
   } cfg_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [1:0]      ch;
      logic            done;
   } cmd_type;

   typedef struct packed {
      logic window_end;
      logic iter_last;
   } sts_type;

endpackage

[sv/tcrms_dp.sv]
// Datapath of the three-channel RMS meter: sums, shared multiplier, square root and divider.
// Depends on tcrms_pkg and the assertion macro header.
`include "three_channel_rms_meter_macros.svh"

module tcrms_dp (
   input  logic              clock,
   input  logic              reset,
   input  tcrms_pkg::cmd_type cmd,
   input  tcrms_pkg::cfg_type cfg,
   input  tcrms_pkg::req_type req_data,
   output tcrms_pkg::sts_type sts,
   output tcrms_pkg::rsp_type rsp_data
);

   logic [tcrms_pkg::SAMPLE_W-1:0] low_smp_ff, low_smp_in;
   logic [tcrms_pkg::SAMPLE_W-1:0] high_smp_ff, high_smp_in;
   logic [tcrms_pkg::SAMPLE_W-1:0] volt_smp_ff, volt_smp_in;
   logic [tcrms_pkg::SUM_W-1:0]    low_sum_ff, low_sum_in;
   logic [tcrms_pkg::SUM_W-1:0]    high_sum_ff, high_sum_in;
   logic [tcrms_pkg::SUM_W-1:0]    volt_sum_ff, volt_sum_in;
   logic [tcrms_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [tcrms_pkg::RMS_W-1:0]    low_rms_ff, low_rms_in;
   logic [tcrms_pkg::RMS_W-1:0]    high_rms_ff, high_rms_in;
   logic [tcrms_pkg::RMS_W-1:0]    volt_rms_ff, volt_rms_in;
   logic [tcrms_pkg::SQUARE_W-1:0] prod_ff, prod_in;
   logic [tcrms_pkg::SQUARE_W-1:0] rad_ff, rad_in;
   logic [tcrms_pkg::SREM_W-1:0]   srem_ff, srem_in;
   logic [tcrms_pkg::ROOT_W-1:0]   root_ff, root_in;
   logic [tcrms_pkg::SAMPLE_W-1:0] drem_ff, drem_in;
   logic [tcrms_pkg::RMS_W-1:0]    quo_ff, quo_in;
   logic [tcrms_pkg::ITER_W-1:0]   iter_ff, iter_in;
   tcrms_pkg::rsp_type             rsp_ff, rsp_in;

   logic [tcrms_pkg::SAMPLE_W-1:0] smp_sel;
   logic [tcrms_pkg::SAMPLE_W-1:0] off_sel;
   logic [tcrms_pkg::SAMPLE_W-1:0] scale_sel;
   logic [tcrms_pkg::SUM_W-1:0]    sum_sel;
   logic [tcrms_pkg::SAMPLE_W-1:0] diff;
   logic [tcrms_pkg::SAMPLE_W-1:0] divisor;
   logic [tcrms_pkg::SAMPLE_W-1:0] mul_a;
   logic [tcrms_pkg::SAMPLE_W-1:0] mul_b;
   logic [tcrms_pkg::SQUARE_W-1:0] mul_res;
   logic [tcrms_pkg::SUM_W-1:0]    sum_new;
   logic [tcrms_pkg::SREM_W+1:0]   srem_trial;
   logic [tcrms_pkg::SREM_W+1:0]   sroot_trial;
   logic                           sqrt_geq;
   logic [tcrms_pkg::SAMPLE_W:0]   drem_trial;
   logic                           div_geq;

   // Channel selection for the operand of the current step.
   always_comb begin
      case (cmd.ch)
         tcrms_pkg::CH_LOW: begin
            smp_sel   = low_smp_ff;
            off_sel   = cfg.low_gain_offset;
            scale_sel = cfg.low_gain_scale;
            sum_sel   = low_sum_ff;
         end
         tcrms_pkg::CH_HIGH: begin
            smp_sel   = high_smp_ff;
            off_sel   = cfg.high_gain_offset;
            scale_sel = cfg.high_gain_scale;
            sum_sel   = high_sum_ff;
         end
         default: begin
            smp_sel   = volt_smp_ff;
            off_sel   = cfg.voltage_offset;
            scale_sel = cfg.voltage_scale;
            sum_sel   = volt_sum_ff;
         end
      endcase
   end

   // Offset correction, divisor guard and the shared multiplier.
   assign diff    = (smp_sel >= off_sel) ? (smp_sel - off_sel) : (off_sel - smp_sel);
   assign divisor = (scale_sel == '0) ? tcrms_pkg::SAMPLE_W'(1) : scale_sel;
   assign mul_a   = (cmd.op == tcrms_pkg::OP_SCALE) ? root_ff : diff;
   assign mul_b   = (cmd.op == tcrms_pkg::OP_SCALE) ? tcrms_pkg::MILLI : diff;
   assign mul_res = tcrms_pkg::SQUARE_W'(mul_a) * tcrms_pkg::SQUARE_W'(mul_b);
   assign sum_new = sum_sel + tcrms_pkg::SUM_W'(prod_ff);

   // One result bit of the square root per step, two radicand bits in.
   assign srem_trial  = {srem_ff, rad_ff[tcrms_pkg::SQUARE_W-1 -: 2]};
   assign sroot_trial = {2'b00, root_ff, 2'b01};
   assign sqrt_geq    = (srem_trial >= sroot_trial);

   // One quotient bit of the restoring divider per step.
   assign drem_trial = {drem_ff, quo_ff[tcrms_pkg::RMS_W-1]};
   assign div_geq    = (drem_trial >= {1'b0, divisor});

   // Next values of all datapath registers.
   always_comb begin
      low_smp_in  = low_smp_ff;
      high_smp_in = high_smp_ff;
      volt_smp_in = volt_smp_ff;
      low_sum_in  = low_sum_ff;
      high_sum_in = high_sum_ff;
      volt_sum_in = volt_sum_ff;
      count_in    = count_ff;
      low_rms_in  = low_rms_ff;
      high_rms_in = high_rms_ff;
      volt_rms_in = volt_rms_ff;
      prod_in     = prod_ff;
      rad_in      = rad_ff;
      srem_in     = srem_ff;
      root_in     = root_ff;
      drem_in     = drem_ff;
      quo_in      = quo_ff;
      iter_in     = iter_ff;
      rsp_in      = rsp_ff;
      case (cmd.op)
         tcrms_pkg::OP_LOAD: begin
            low_smp_in  = req_data.low_gain_sample;
            high_smp_in = req_data.high_gain_sample;
            volt_smp_in = req_data.voltage_sample;
         end
         tcrms_pkg::OP_CLEAR_ALL: begin
            low_sum_in  = '0;
            high_sum_in = '0;
            volt_sum_in = '0;
            count_in    = '0;
            low_rms_in  = '0;
            high_rms_in = '0;
            volt_rms_in = '0;
         end
         tcrms_pkg::OP_SQUARE, tcrms_pkg::OP_SCALE: begin
            prod_in = mul_res;
         end
         tcrms_pkg::OP_ACCUM: begin
            case (cmd.ch)
               tcrms_pkg::CH_LOW:  low_sum_in  = sum_new;
               tcrms_pkg::CH_HIGH: high_sum_in = sum_new;
               default:            volt_sum_in = sum_new;
            endcase
         end
         tcrms_pkg::OP_TICK: begin
            count_in = sts.window_end ? '0 : count_ff + tcrms_pkg::CNT_W'(1);
         end
         tcrms_pkg::OP_ROOT_INIT: begin
            rad_in  = sum_sel[tcrms_pkg::SUM_W-1:tcrms_pkg::SAMPLE_SHIFT];
            srem_in = '0;
            root_in = '0;
            iter_in = tcrms_pkg::ITER_W'(tcrms_pkg::SQRT_STEPS - 1);
         end
         tcrms_pkg::OP_ROOT_STEP: begin
            srem_in = sqrt_geq ? tcrms_pkg::SREM_W'(srem_trial - sroot_trial)
                               : tcrms_pkg::SREM_W'(srem_trial);
            root_in = {root_ff[tcrms_pkg::ROOT_W-2:0], sqrt_geq};
            rad_in  = {rad_ff[tcrms_pkg::SQUARE_W-3:0], 2'b00};
            iter_in = iter_ff - tcrms_pkg::ITER_W'(1);
         end
         tcrms_pkg::OP_DIV_INIT: begin
            quo_in  = prod_ff[tcrms_pkg::RMS_W-1:0];
            drem_in = '0;
            iter_in = tcrms_pkg::ITER_W'(tcrms_pkg::DIV_STEPS - 1);
         end
         tcrms_pkg::OP_DIV_STEP: begin
            drem_in = div_geq ? tcrms_pkg::SAMPLE_W'(drem_trial - {1'b0, divisor})
                              : drem_trial[tcrms_pkg::SAMPLE_W-1:0];
            quo_in  = {quo_ff[tcrms_pkg::RMS_W-2:0], div_geq};
            iter_in = iter_ff - tcrms_pkg::ITER_W'(1);
         end
         tcrms_pkg::OP_STORE: begin
            // The channel's window sum is finished with once its value is stored.
            case (cmd.ch)
               tcrms_pkg::CH_LOW: begin
                  low_rms_in = quo_ff;
                  low_sum_in = '0;
               end
               tcrms_pkg::CH_HIGH: begin
                  high_rms_in = quo_ff;
                  high_sum_in = '0;
               end
               default: begin
                  volt_rms_in = quo_ff;
                  volt_sum_in = '0;
               end
            endcase
         end
         tcrms_pkg::OP_PUBLISH: begin
            rsp_in.low_gain_rms  = low_rms_ff;
            rsp_in.high_gain_rms = high_rms_ff;
            rsp_in.voltage_rms   = volt_rms_ff;
            rsp_in.window_done   = cmd.done;
         end
         default: begin
         end
      endcase
   end

   // Accumulated state is cleared by reset; working registers carry payload only.
   always_ff @(posedge clock) begin
      if (reset) begin
         low_sum_ff  <= '0;
         high_sum_ff <= '0;
         volt_sum_ff <= '0;
         count_ff    <= '0;
         low_rms_ff  <= '0;
         high_rms_ff <= '0;
         volt_rms_ff <= '0;
      end else begin
         low_sum_ff  <= low_sum_in;
         high_sum_ff <= high_sum_in;
         volt_sum_ff <= volt_sum_in;
         count_ff    <= count_in;
         low_rms_ff  <= low_rms_in;
         high_rms_ff <= high_rms_in;
         volt_rms_ff <= volt_rms_in;
      end
   end

   always_ff @(posedge clock) begin
      low_smp_ff  <= low_smp_in;
      high_smp_ff <= high_smp_in;
      volt_smp_ff <= volt_smp_in;
      prod_ff     <= prod_in;
      rad_ff      <= rad_in;
      srem_ff     <= srem_in;
      root_ff     <= root_in;
      drem_ff     <= drem_in;
      quo_ff      <= quo_in;
      iter_ff     <= iter_in;
      rsp_ff      <= rsp_in;
   end

   // Status back to the controller.
   assign sts.window_end = (count_ff == tcrms_pkg::CNT_W'(tcrms_pkg::WINDOW_LEN - 1));
   assign sts.iter_last  = (iter_ff == '0);
   assign rsp_data       = rsp_ff;

   // The divider remainder always stays below the divisor.
   `TCRMS_ASSERT(dp_div_rem_bound, clock, reset, ((cmd.op == tcrms_pkg::OP_DIV_STEP) |-> (drem_ff < divisor)))
   // The square root remainder never exceeds twice the partial root.
   `TCRMS_ASSERT(dp_sqrt_rem_bound, clock, reset, ((cmd.op == tcrms_pkg::OP_ROOT_STEP) |-> (srem_ff <= tcrms_pkg::SREM_W'({root_ff, 1'b0}))))

endmodule

[sv/tcrms_ctrl.sv]
// Controller of the three-channel RMS meter: sequences the datapath and runs the handshakes.
// Depends on tcrms_pkg and the assertion macro header.
`include "three_channel_rms_meter_macros.svh"

module tcrms_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_restart,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  tcrms_pkg::sts_type sts,
   output tcrms_pkg::cmd_type cmd
);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_SQUARE    = 4'd1;
   localparam logic [3:0] S_ACCUM     = 4'd2;
   localparam logic [3:0] S_TICK      = 4'd3;
   localparam logic [3:0] S_ROOT_INIT = 4'd4;
   localparam logic [3:0] S_ROOT      = 4'd5;
   localparam logic [3:0] S_SCALE     = 4'd6;
   localparam logic [3:0] S_DIV_INIT  = 4'd7;
   localparam logic [3:0] S_DIV       = 4'd8;
   localparam logic [3:0] S_STORE     = 4'd9;
   localparam logic [3:0] S_OUT       = 4'd10;

   logic [3:0] state_ff, state_in;
   logic [1:0] ch_ff, ch_in;
   logic       done_ff, done_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_xfer;
   logic       out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Next state and the command for this cycle.
   always_comb begin
      state_in     = state_ff;
      ch_in        = ch_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op       = tcrms_pkg::OP_NONE;
      cmd.ch       = ch_ff;
      cmd.done     = done_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               ch_in   = tcrms_pkg::CH_LOW;
               done_in = 1'b0;
               if (req_restart) begin
                  cmd.op   = tcrms_pkg::OP_CLEAR_ALL;
                  state_in = S_OUT;
               end else begin
                  cmd.op   = tcrms_pkg::OP_LOAD;
                  state_in = S_SQUARE;
               end
            end
         end
         S_SQUARE: begin
            cmd.op   = tcrms_pkg::OP_SQUARE;
            state_in = S_ACCUM;
         end
         S_ACCUM: begin
            cmd.op = tcrms_pkg::OP_ACCUM;
            if (ch_ff == tcrms_pkg::CH_VOLT) begin
               state_in = S_TICK;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = S_SQUARE;
            end
         end
         S_TICK: begin
            cmd.op = tcrms_pkg::OP_TICK;
            ch_in  = tcrms_pkg::CH_LOW;
            if (sts.window_end) begin
               done_in  = 1'b1;
               state_in = S_ROOT_INIT;
            end else begin
               state_in = S_OUT;
            end
         end
         S_ROOT_INIT: begin
            cmd.op   = tcrms_pkg::OP_ROOT_INIT;
            state_in = S_ROOT;
         end
         S_ROOT: begin
            cmd.op = tcrms_pkg::OP_ROOT_STEP;
            if (sts.iter_last) begin
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            cmd.op   = tcrms_pkg::OP_SCALE;
            state_in = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            cmd.op   = tcrms_pkg::OP_DIV_INIT;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = tcrms_pkg::OP_DIV_STEP;
            if (sts.iter_last) begin
               state_in = S_STORE;
            end
         end
         S_STORE: begin
            cmd.op = tcrms_pkg::OP_STORE;
            if (ch_ff == tcrms_pkg::CH_VOLT) begin
               state_in = S_OUT;
            end else begin
               ch_in    = ch_ff + 2'd1;
               state_in = S_ROOT_INIT;
            end
         end
         S_OUT: begin
            // Wait until the output register is free, then load the result.
            if (out_free) begin
               cmd.op       = tcrms_pkg::OP_PUBLISH;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff   <= ch_in;
      done_ff <= done_in;
   end

   assign rsp_valid = rsp_valid_ff;

   // A new result only appears after the output state has loaded it.
   `TCRMS_ASSERT(ctrl_rsp_from_out, clock, reset, ($rose(rsp_valid_ff) |-> $past(state_ff == S_OUT)))
   // While a channel step runs, the channel code stays within the three channels.
   `TCRMS_ASSERT(ctrl_ch_range, clock, reset, ((state_ff != S_IDLE) |-> (ch_ff <= tcrms_pkg::CH_VOLT)))
   // Reset leaves the controller idle with no result pending.
   `TCRMS_ASSERT_RESET(ctrl_reset_idle, clock, (reset |=> ((state_ff == S_IDLE) && !rsp_valid_ff)))

endmodule

[sv/three_channel_rms_meter.sv]
// Three-channel RMS meter. An item that does not close a window is squared and summed per
// channel before its result is loaded; the item that closes a window also runs the shared
// 16-step square root and 26-step divider once per channel. A restart item clears all sums and readings.
// One item is in work at a time. The next transfer in follows in the cycle after a result is
// loaded, and a result is loaded only while the output register is free to take it.
// Reset is synchronous and active high; it restores register defaults and clears all sums.
module three_channel_rms_meter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  tcrms_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output tcrms_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tcrms_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tcrms_pkg::SAMPLE_W-1:0]       csr_data
);

   tcrms_pkg::cfg_type cfg_ff, cfg_in;
   tcrms_pkg::cmd_type cmd;
   tcrms_pkg::sts_type sts;

   // Configuration registers; indexes past the list are ignored.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            tcrms_pkg::CSR_LOW_SCALE:   cfg_in.low_gain_scale   = csr_data;
            tcrms_pkg::CSR_LOW_OFFSET:  cfg_in.low_gain_offset  = csr_data;
            tcrms_pkg::CSR_HIGH_SCALE:  cfg_in.high_gain_scale  = csr_data;
            tcrms_pkg::CSR_HIGH_OFFSET: cfg_in.high_gain_offset = csr_data;
            tcrms_pkg::CSR_VOLT_SCALE:  cfg_in.voltage_scale    = csr_data;
            tcrms_pkg::CSR_VOLT_OFFSET: cfg_in.voltage_offset   = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_gain_scale   <= tcrms_pkg::LOW_SCALE_RST;
         cfg_ff.low_gain_offset  <= tcrms_pkg::OFFSET_RST;
         cfg_ff.high_gain_scale  <= tcrms_pkg::HIGH_SCALE_RST;
         cfg_ff.high_gain_offset <= tcrms_pkg::OFFSET_RST;
         cfg_ff.voltage_scale    <= tcrms_pkg::VOLT_SCALE_RST;
         cfg_ff.voltage_offset   <= tcrms_pkg::OFFSET_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Sequencer.
   tcrms_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_data.restart),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .sts         (sts),
      .cmd         (cmd)
   );

   // Arithmetic and held values.
   tcrms_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cfg      (cfg_ff),
      .req_data (req_data),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

[tb/three_channel_rms_meter_test.sv]
// Self-checking testbench for the three-channel RMS meter (three_channel_rms_meter).
// Depends on tcrms_pkg and the RTL of the block; predicts every result and checks each field.
module three_channel_rms_meter_test;
   import tcrms_pkg::*;

   // Register indexes that map to nothing; writes to them must be ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_HI = 3'd7;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [SAMPLE_W-1:0]  csr_data;

   // Shadow copy of the registers and the meter state.
   cfg_type          meter_regs;
   logic [SUM_W-1:0] low_sum, high_sum, volt_sum;
   int unsigned      ticks_in_window;
   logic [RMS_W-1:0] held_low, held_high, held_volt;

   // Readings predicted at each input transfer, oldest first.
   rsp_type pending_readings[$];

   int unsigned error_count     = 0;
   int unsigned samples_taken   = 0;
   int unsigned restarts_taken  = 0;
   int unsigned windows_closed  = 0;
   int unsigned send_idle_pct   = 0;
   int unsigned rsp_stall_pct   = 0;
   int unsigned hold_off_cycles = 0;

   three_channel_rms_meter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Exact square of the distance between a converter code and its offset.
   function automatic logic [SQUARE_W-1:0] offset_square(input logic [SAMPLE_W-1:0] code,
                                                         input logic [SAMPLE_W-1:0] zero);
      logic [SQUARE_W-1:0] delta;
      delta = (code >= zero) ? SQUARE_W'(code - zero) : SQUARE_W'(zero - code);
      return delta * delta;
   endfunction

   // Floor square root, one result bit at a time from the top.
   function automatic logic [ROOT_W-1:0] floor_sqrt(input logic [SQUARE_W-1:0] mean);
      logic [ROOT_W-1:0]   root;
      logic [ROOT_W-1:0]   trial;
      logic [SQUARE_W-1:0] wide;
      root = '0;
      for (int b = ROOT_W - 1; b >= 0; b--) begin
         trial    = root;
         trial[b] = 1'b1;
         wide     = SQUARE_W'(trial);
         if (wide * wide <= mean) root = trial;
      end
      return root;
   endfunction

   // Mean square to RMS in milli-units; a zero scale divides by one.
   function automatic logic [RMS_W-1:0] scaled_rms(input logic [SUM_W-1:0] sum,
                                                   input logic [SAMPLE_W-1:0] scale);
      logic [SQUARE_W-1:0] mean;
      logic [63:0]         milli;
      logic [63:0]         divisor;
      mean    = SQUARE_W'(sum >> SAMPLE_SHIFT);
      milli   = 64'(floor_sqrt(mean));
      milli   = milli * 64'd1000;
      divisor = 64'(scale);
      if (scale == '0) divisor = 64'd1;
      return RMS_W'(milli / divisor);
   endfunction

   // Applies one input item to the shadow state and returns the reading it should give.
   function automatic rsp_type advance_meter(input req_type item);
      rsp_type reading;
      reading.window_done = 1'b0;
      if (item.restart) begin
         low_sum = '0; high_sum = '0; volt_sum = '0;
         ticks_in_window = 0;
         held_low = '0; held_high = '0; held_volt = '0;
      end else begin
         low_sum  += SUM_W'(offset_square(item.low_gain_sample, meter_regs.low_gain_offset));
         high_sum += SUM_W'(offset_square(item.high_gain_sample, meter_regs.high_gain_offset));
         volt_sum += SUM_W'(offset_square(item.voltage_sample, meter_regs.voltage_offset));
         ticks_in_window++;
         if (ticks_in_window >= WINDOW_LEN) begin
            held_low  = scaled_rms(low_sum, meter_regs.low_gain_scale);
            held_high = scaled_rms(high_sum, meter_regs.high_gain_scale);
            held_volt = scaled_rms(volt_sum, meter_regs.voltage_scale);
            low_sum = '0; high_sum = '0; volt_sum = '0;
            ticks_in_window = 0;
            reading.window_done = 1'b1;
         end
      end
      reading.low_gain_rms  = held_low;
      reading.high_gain_rms = held_high;
      reading.voltage_rms   = held_volt;
      return reading;
   endfunction

   function automatic cfg_type default_regs();
      cfg_type regs;
      regs.low_gain_scale   = LOW_SCALE_RST;
      regs.low_gain_offset  = OFFSET_RST;
      regs.high_gain_scale  = HIGH_SCALE_RST;
      regs.high_gain_offset = OFFSET_RST;
      regs.voltage_scale    = VOLT_SCALE_RST;
      regs.voltage_offset   = OFFSET_RST;
      return regs;
   endfunction

   function automatic req_type make_item(input logic restart, input logic [SAMPLE_W-1:0] low,
                                         input logic [SAMPLE_W-1:0] high,
                                         input logic [SAMPLE_W-1:0] volt);
      req_type item;
      item.restart          = restart;
      item.low_gain_sample  = low;
      item.high_gain_sample = high;
      item.voltage_sample   = volt;
      return item;
   endfunction

   // Codes at the rails, close to the offset, or anywhere.
   function automatic logic [SAMPLE_W-1:0] pick_code(input logic [SAMPLE_W-1:0] zero);
      logic [SAMPLE_W-1:0] jitter;
      jitter = SAMPLE_W'($urandom_range(0, 128));
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return zero + jitter - 16'd64;
         default: return SAMPLE_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_scale();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return 16'd1;
         2:       return '1;
         3:       return SAMPLE_W'($urandom_range(1, 100));
         default: return SAMPLE_W'($urandom_range(1, 65535));
      endcase
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_offset();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return '1;
         2:       return OFFSET_RST;
         default: return SAMPLE_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic req_type random_item(input int unsigned restart_pct);
      return make_item($urandom_range(0, 99) < restart_pct,
                       pick_code(meter_regs.low_gain_offset),
                       pick_code(meter_regs.high_gain_offset),
                       pick_code(meter_regs.voltage_offset));
   endfunction

   // Offers one item, after a random gap, and returns once it has transferred.
   // Valid stays high so that the next call can follow without a bubble.
   task automatic send_sample(input req_type item);
      int unsigned gap;
      gap = 0;
      if ($urandom_range(0, 99) < send_idle_pct) gap = $urandom_range(1, 20);
      @(negedge clock);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
   endtask

   // Drops valid and waits until every predicted reading has come back.
   task automatic settle_meter();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] code);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= code;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_LOW_SCALE:   meter_regs.low_gain_scale   = code;
         CSR_LOW_OFFSET:  meter_regs.low_gain_offset  = code;
         CSR_HIGH_SCALE:  meter_regs.high_gain_scale  = code;
         CSR_HIGH_OFFSET: meter_regs.high_gain_offset = code;
         CSR_VOLT_SCALE:  meter_regs.voltage_scale    = code;
         CSR_VOLT_OFFSET: meter_regs.voltage_offset   = code;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_registers(input cfg_type regs);
      settle_meter();
      write_reg(CSR_LOW_SCALE, regs.low_gain_scale);
      write_reg(CSR_LOW_OFFSET, regs.low_gain_offset);
      write_reg(CSR_HIGH_SCALE, regs.high_gain_scale);
      write_reg(CSR_HIGH_OFFSET, regs.high_gain_offset);
      write_reg(CSR_VOLT_SCALE, regs.voltage_scale);
      write_reg(CSR_VOLT_OFFSET, regs.voltage_offset);
   endtask

   // Restart straight after reset and mid-window, and codes at the rails and on the offset.
   task automatic test_restart_and_extremes();
      send_sample(make_item(1'b1, '1, '1, '1));
      send_sample(make_item(1'b0, '0, '0, '0));
      send_sample(make_item(1'b0, '1, '1, '1));
      send_sample(make_item(1'b0, OFFSET_RST, OFFSET_RST, OFFSET_RST));
      send_sample(make_item(1'b0, 16'h5555, 16'hAAAA, 16'h5555));
      send_sample(make_item(1'b0, 16'hAAAA, 16'h5555, 16'hAAAA));
      send_sample(make_item(1'b1, '0, '0, '0));
      send_sample(make_item(1'b0, 16'd1, 16'h7FFF, 16'h8001));
      send_sample(make_item(1'b1, 16'h1234, 16'hFEDC, 16'h0F0F));
   endtask

   // Largest possible reading, then the largest offset with the largest scale.
   task automatic test_full_scale();
      cfg_type regs;
      regs = '{default: '0};
      regs.low_gain_scale = 16'd1; regs.high_gain_scale = 16'd1; regs.voltage_scale = 16'd1;
      load_registers(regs);
      repeat (WINDOW_LEN) send_sample(make_item(1'b0, '1, '1, '1));
      regs = '{default: '1};
      load_registers(regs);
      repeat (WINDOW_LEN) send_sample(make_item(1'b0, '0, '0, '0));
   endtask

   // A zero scale must behave as a divisor of one.
   task automatic test_zero_scale();
      cfg_type regs;
      regs.low_gain_scale   = '0;
      regs.low_gain_offset  = pick_offset();
      regs.high_gain_scale  = '0;
      regs.high_gain_offset = pick_offset();
      regs.voltage_scale    = '0;
      regs.voltage_offset   = pick_offset();
      load_registers(regs);
      repeat (WINDOW_LEN) send_sample(random_item(0));
   endtask

   // Writes to unmapped indexes must leave the defaults in force for a whole window.
   task automatic test_unmapped_index();
      load_registers(default_regs());
      write_reg(CSR_UNMAPPED_LO, '1);
      write_reg(CSR_UNMAPPED_HI, SAMPLE_W'($urandom_range(0, 65535)));
      repeat (WINDOW_LEN) send_sample(random_item(0));
   endtask

   // Random items with a two percent chance of restart each, under each idling mix and fresh registers.
   task automatic test_random_windows();
      cfg_type regs;
      int unsigned idle_mix[4][2] = '{'{0, 0}, '{60, 0}, '{0, 60}, '{15, 15}};
      for (int mix = 0; mix < 4; mix++) begin
         for (int pass = 0; pass < 4; pass++) begin
            regs.low_gain_scale   = pick_scale();
            regs.low_gain_offset  = pick_offset();
            regs.high_gain_scale  = pick_scale();
            regs.high_gain_offset = pick_offset();
            regs.voltage_scale    = pick_scale();
            regs.voltage_offset   = pick_offset();
            load_registers(regs);
            send_idle_pct = idle_mix[mix][0];
            rsp_stall_pct = idle_mix[mix][1];
            repeat ($urandom_range(40, 60)) send_sample(random_item(2));
         end
      end
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   // The output is held off for a long stretch while items keep coming, so the input stalls.
   task automatic test_output_hold_off();
      load_registers(default_regs());
      hold_off_cycles = 400;
      repeat (30) send_sample(random_item(0));
   endtask

   // Receiver stall: a counted hold-off when one is asked for, otherwise random.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_off_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
         end
      end
   end

   // Predict a reading for every input transfer.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         pending_readings.push_back(advance_meter(req_data));
         if (req_data.restart) restarts_taken++;
         else samples_taken++;
      end
   end

   task automatic compare_field(input string name, input logic [RMS_W-1:0] want,
                                input logic [RMS_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Check each result transfer against the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected reading, expected none, got %h", $time, rsp_data);
            error_count++;
         end else begin
            want = pending_readings.pop_front();
            compare_field("low_gain_rms", want.low_gain_rms, rsp_data.low_gain_rms);
            compare_field("high_gain_rms", want.high_gain_rms, rsp_data.high_gain_rms);
            compare_field("voltage_rms", want.voltage_rms, rsp_data.voltage_rms);
            compare_field("window_done", RMS_W'(want.window_done),
                          RMS_W'(rsp_data.window_done));
            if (want.window_done) windows_closed++;
         end
      end
   end

   // Run limit, well beyond the slowest correct run.
   initial begin
      #20000000;
      $display("%0t: timed out with %0d readings outstanding", $time, pending_readings.size());
      $display("three_channel_rms_meter_test: errors");
      $finish;
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      meter_regs = default_regs();
      low_sum = '0; high_sum = '0; volt_sum = '0;
      ticks_in_window = 0;
      held_low = '0; held_high = '0; held_volt = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_restart_and_extremes();
      test_full_scale();
      test_zero_scale();
      test_unmapped_index();
      test_random_windows();
      test_output_hold_off();

      settle_meter();
      repeat (160) @(posedge clock);
      $display("Sent %0d samples and %0d restarts; %0d windows closed.",
               samples_taken, restarts_taken, windows_closed);
      $display("Covered rail codes, zero and full scales, unmapped writes and output hold-off.");
      if (error_count == 0) begin
         $display("three_channel_rms_meter_test: clean");
      end else begin
         $display("three_channel_rms_meter_test: errors");
      end
      $finish;
   end

endmodule

[three_channel_rms_meter.f]
+incdir+sv
sv/tcrms_pkg.sv
sv/tcrms_dp.sv
sv/tcrms_ctrl.sv
sv/three_channel_rms_meter.sv
tb/three_channel_rms_meter_test.sv
